FILE: hdl/lbs_pkg.sv
// lbs_pkg: shared types, codes and reset constants for the leaky bucket shaper.
// No dependencies.
`timescale 1ns / 1ps
package lbs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SIZE_BITS_DEF   = 12;
  localparam int TAG_BITS        = 16;
  localparam int TICK_BITS       = 16;
  localparam int ELAPSED_BITS    = 17;
  localparam int MAX_RESULTS     = 16;
  localparam int CNT_BITS        = $clog2(MAX_RESULTS + 1);

  localparam int BUCKET_RESET = 50;
  localparam int RATE_RESET   = 5;
  localparam int REFILL_RESET = 1000;

  localparam logic [1:0] REG_BUCKET = 2'd0;
  localparam logic [1:0] REG_RATE   = 2'd1;
  localparam logic [1:0] REG_REFILL = 2'd2;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_DROP   = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;
  localparam logic [1:0] KIND_SENT   = 2'd3;

  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE,
    ST_FREE,
    ST_TICK,
    ST_READ,
    ST_CHECK,
    ST_RETURN,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ADDSAT
  } alu_op_t;

  typedef struct packed {
    logic accept;
    logic cmd_tick;
    logic drain_ok;
    logic fits;
  } status_t;

  typedef struct packed {
    logic busy;
    logic do_size;
    logic do_free;
    logic do_tick;
    logic do_read;
    logic do_check;
    logic do_return;
    logic do_done;
  } ctrl_t;

endpackage

FILE: hdl/leaky_bucket_packet_shaper.sv
// leaky_bucket_packet_shaper: top level, datapath registers, queue pointers, result buffer.
// Depends on lbs_pkg, lbs_alu, lbs_desc_ram, lbs_ctrl.
//
// Channel   Direction  Signals                                  Handshake
// request   in         command, pkt_len, packet_tag             start & !busy
// result    out        result_kind, out_tag, out_size, last     result_valid, one cycle
// config    in         wr_index, wr_data                        wr_en, no wait
//
// Arrival states: size, free, read, done; tick states: tick, read, done. A packet sent adds
// check, return, read; a held-back head adds check. Shared ALU and registered read set this.
// Each result is held until the next one is made or the request ends, so the final one
// can carry last; that one shows in the first idle cycle after busy drops.
// Reset clears control state and reloads the config registers, free space and credit from lbs_pkg.
// The receiver cannot stall; there is no back-pressure on results.
`timescale 1ns / 1ps
module leaky_bucket_packet_shaper #(
  parameter int QUEUE_DEPTH = lbs_pkg::QUEUE_DEPTH_DEF,
  parameter int SIZE_BITS   = lbs_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [SIZE_BITS-1:0]          pkt_len,
  input  logic [lbs_pkg::TAG_BITS-1:0]  packet_tag,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [((SIZE_BITS > lbs_pkg::TICK_BITS) ? SIZE_BITS : lbs_pkg::TICK_BITS)-1:0] wr_data,
  output logic                          result_valid,
  output logic [1:0]                    result_kind,
  output logic [lbs_pkg::TAG_BITS-1:0]  out_tag,
  output logic [SIZE_BITS-1:0]          out_size,
  output logic                          last
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = SIZE_BITS + PW;
  localparam int TW = lbs_pkg::TAG_BITS;
  localparam int DW = TW + SIZE_BITS;
  localparam int EW = lbs_pkg::ELAPSED_BITS;
  localparam int CW = lbs_pkg::CNT_BITS;
  localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};

  lbs_pkg::ctrl_t   ctrl;
  lbs_pkg::status_t status;

  logic [SIZE_BITS-1:0] bucket_bytes;
  logic [SIZE_BITS-1:0] bytes_per_interval;
  logic [lbs_pkg::TICK_BITS-1:0] refill_ticks;

  logic [SIZE_BITS-1:0] free_space;
  logic [SIZE_BITS-1:0] send_credit;
  logic [EW-1:0]        elapsed_ticks;
  logic [QW-1:0]        queued_sum;
  logic [PW-1:0]        queue_head;
  logic [PW-1:0]        queue_tail;
  logic [QCW-1:0]       queue_count;
  logic [CW-1:0]        n_results;

  logic                 req_cmd;
  logic [SIZE_BITS-1:0] req_size;
  logic [TW-1:0]        req_tag;
  logic                 too_big;

  logic                 pend_valid;
  logic [1:0]           pend_kind;
  logic [TW-1:0]        pend_tag;
  logic [SIZE_BITS-1:0] pend_size;

  logic [DW-1:0]        head_data;
  logic [SIZE_BITS-1:0] head_size;
  logic [TW-1:0]        head_tag;

  lbs_pkg::alu_op_t     alu_op;
  logic [SIZE_BITS-1:0] alu_a;
  logic [SIZE_BITS-1:0] alu_b;
  logic [SIZE_BITS-1:0] alu_res;
  logic                 alu_borrow;

  logic                 accept;
  logic                 q_full;
  logic                 enq;
  logic                 send;
  logic                 new_res;
  logic [1:0]           new_kind;
  logic [TW-1:0]        new_tag;
  logic [SIZE_BITS-1:0] new_size;
  logic [EW-1:0]        elapsed_inc;
  logic [QW-1:0]        bucket_ext;
  logic [PW-1:0]        tail_next;
  logic [PW-1:0]        head_next;

  assign busy      = ctrl.busy;
  assign accept    = start && !ctrl.busy;
  assign head_size = head_data[SIZE_BITS-1:0];
  assign head_tag  = head_data[DW-1:SIZE_BITS];
  assign q_full    = (queue_count == QCW'(QUEUE_DEPTH));
  assign enq       = ctrl.do_free && !too_big && !alu_borrow && !q_full;
  assign send      = ctrl.do_check && !alu_borrow;
  assign tail_next = (queue_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : queue_tail + 1'b1;
  assign head_next = (queue_head == PW'(QUEUE_DEPTH - 1)) ? '0 : queue_head + 1'b1;
  assign bucket_ext = QW'(wr_data[SIZE_BITS-1:0]);
  assign elapsed_inc = (elapsed_ticks < ELAPSED_MAX) ? elapsed_ticks + 1'b1 : elapsed_ticks;

  always_comb begin
    status.accept   = accept;
    status.cmd_tick = (command == lbs_pkg::CMD_TICK);
    status.drain_ok = (queue_count != '0) && (n_results != CW'(lbs_pkg::MAX_RESULTS));
    status.fits     = !alu_borrow;
  end

  lbs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_op = lbs_pkg::ALU_SUB;
    alu_a  = free_space;
    alu_b  = req_size;
    if (ctrl.do_size) begin
      alu_a = bytes_per_interval;
    end else if (ctrl.do_check) begin
      alu_a = send_credit;
      alu_b = head_size;
    end else if (ctrl.do_return) begin
      alu_op = lbs_pkg::ALU_ADDSAT;
      alu_b  = head_size;
    end
  end

  lbs_alu #(.W(SIZE_BITS)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  lbs_desc_ram #(.DEPTH(QUEUE_DEPTH), .DW(DW)) u_ram (
    .clk   (clk),
    .we    (enq),
    .waddr (queue_tail),
    .wdata ({req_tag, req_size}),
    .re    (ctrl.do_read),
    .raddr (queue_head),
    .rdata (head_data)
  );

  always_comb begin
    new_res  = ctrl.do_free || send;
    new_kind = lbs_pkg::KIND_SENT;
    new_tag  = head_tag;
    new_size = head_size;
    if (ctrl.do_free) begin
      new_tag  = req_tag;
      new_size = req_size;
      if (too_big || alu_borrow) begin
        new_kind = lbs_pkg::KIND_DROP;
      end else if (q_full) begin
        new_kind = lbs_pkg::KIND_FULL;
      end else begin
        new_kind = lbs_pkg::KIND_ACCEPT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd  <= command;
      req_size <= pkt_len;
      req_tag  <= packet_tag;
    end
    if (ctrl.do_size) begin
      too_big <= alu_borrow;
    end
  end

  // configuration and bucket state
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_bytes       <= SIZE_BITS'(lbs_pkg::BUCKET_RESET);
      bytes_per_interval <= SIZE_BITS'(lbs_pkg::RATE_RESET);
      refill_ticks       <= lbs_pkg::TICK_BITS'(lbs_pkg::REFILL_RESET);
      free_space         <= SIZE_BITS'(lbs_pkg::BUCKET_RESET);
      send_credit        <= SIZE_BITS'(lbs_pkg::RATE_RESET);
      elapsed_ticks      <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          lbs_pkg::REG_BUCKET: begin
            bucket_bytes <= wr_data[SIZE_BITS-1:0];
            free_space   <= (queued_sum >= bucket_ext) ? '0 :
                            SIZE_BITS'(bucket_ext - queued_sum);
          end
          lbs_pkg::REG_RATE: begin
            bytes_per_interval <= wr_data[SIZE_BITS-1:0];
            send_credit        <= wr_data[SIZE_BITS-1:0];
          end
          lbs_pkg::REG_REFILL: refill_ticks <= wr_data[lbs_pkg::TICK_BITS-1:0];
          default: ;
        endcase
      end
      if (enq || ctrl.do_return) begin
        free_space <= alu_res;
      end
      if (send) begin
        send_credit <= alu_res;
      end
      if (ctrl.do_tick && req_cmd == lbs_pkg::CMD_TICK) begin
        if (elapsed_inc > EW'(refill_ticks)) begin
          send_credit   <= bytes_per_interval;
          elapsed_ticks <= '0;
        end else begin
          elapsed_ticks <= elapsed_inc;
        end
      end
    end
  end

  // queue pointers and result count
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      queued_sum  <= '0;
      n_results   <= '0;
    end else begin
      if (accept) begin
        n_results <= '0;
      end else if (new_res) begin
        n_results <= n_results + 1'b1;
      end
      if (enq) begin
        queue_tail  <= tail_next;
        queue_count <= queue_count + 1'b1;
        queued_sum  <= queued_sum + QW'(req_size);
      end
      if (send) begin
        queue_head  <= head_next;
        queue_count <= queue_count - 1'b1;
        queued_sum  <= queued_sum - QW'(head_size);
      end
    end
  end

  // one-deep hold so the final result of a request carries last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      last         <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      last         <= 1'b0;
      if (new_res) begin
        pend_valid   <= 1'b1;
        result_valid <= pend_valid;
      end else if (ctrl.do_done) begin
        pend_valid   <= 1'b0;
        result_valid <= pend_valid;
        last         <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_res) begin
      pend_kind <= new_kind;
      pend_tag  <= new_tag;
      pend_size <= new_size;
    end
    if (new_res || ctrl.do_done) begin
      result_kind <= pend_kind;
      out_tag     <= pend_tag;
      out_size    <= pend_size;
    end
  end

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy)
    else $error("last result while still busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("non-final result after request finished");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but sequencer stayed idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    queue_count <= QCW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    n_results <= CW'(lbs_pkg::MAX_RESULTS))
    else $error("too many results for one request");

endmodule

FILE: hdl/lbs_alu.sv
// lbs_alu: shared subtract/compare and saturating add unit.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
module lbs_alu #(
  parameter int W = lbs_pkg::SIZE_BITS_DEF
) (
  input  lbs_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             borrow
);

  logic [W:0] diff;
  logic [W:0] sum;

  assign diff   = {1'b0, a} - {1'b0, b};
  assign sum    = {1'b0, a} + {1'b0, b};
  assign borrow = diff[W];

  always_comb begin
    unique case (op)
      lbs_pkg::ALU_SUB:    res = diff[W-1:0];
      lbs_pkg::ALU_ADDSAT: res = sum[W] ? {W{1'b1}} : sum[W-1:0];
      default:             res = diff[W-1:0];
    endcase
  end

endmodule

FILE: hdl/lbs_desc_ram.sv
// lbs_desc_ram: descriptor queue storage, one write and one registered read port.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
module lbs_desc_ram #(
  parameter int DEPTH = lbs_pkg::QUEUE_DEPTH_DEF,
  parameter int DW    = lbs_pkg::TAG_BITS + lbs_pkg::SIZE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/lbs_ctrl.sv
// lbs_ctrl: sequencer that steps one request through admit or tick, then drain.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
module lbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  lbs_pkg::status_t status,
  output lbs_pkg::ctrl_t   ctrl
);

  lbs_pkg::state_t state;
  lbs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lbs_pkg::ST_IDLE: begin
        if (status.accept) begin
          state_next = status.cmd_tick ? lbs_pkg::ST_TICK : lbs_pkg::ST_SIZE;
        end
      end
      lbs_pkg::ST_SIZE:   state_next = lbs_pkg::ST_FREE;
      lbs_pkg::ST_FREE:   state_next = lbs_pkg::ST_READ;
      lbs_pkg::ST_TICK:   state_next = lbs_pkg::ST_READ;
      lbs_pkg::ST_READ: begin
        state_next = status.drain_ok ? lbs_pkg::ST_CHECK : lbs_pkg::ST_DONE;
      end
      lbs_pkg::ST_CHECK: begin
        state_next = status.fits ? lbs_pkg::ST_RETURN : lbs_pkg::ST_DONE;
      end
      lbs_pkg::ST_RETURN: state_next = lbs_pkg::ST_READ;
      lbs_pkg::ST_DONE:   state_next = lbs_pkg::ST_IDLE;
      default:            state_next = lbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      lbs_pkg::ST_IDLE:   ctrl.busy = 1'b0;
      lbs_pkg::ST_SIZE:   begin ctrl.busy = 1'b1; ctrl.do_size   = 1'b1; end
      lbs_pkg::ST_FREE:   begin ctrl.busy = 1'b1; ctrl.do_free   = 1'b1; end
      lbs_pkg::ST_TICK:   begin ctrl.busy = 1'b1; ctrl.do_tick   = 1'b1; end
      lbs_pkg::ST_READ:   begin ctrl.busy = 1'b1; ctrl.do_read   = 1'b1; end
      lbs_pkg::ST_CHECK:  begin ctrl.busy = 1'b1; ctrl.do_check  = 1'b1; end
      lbs_pkg::ST_RETURN: begin ctrl.busy = 1'b1; ctrl.do_return = 1'b1; end
      lbs_pkg::ST_DONE:   begin ctrl.busy = 1'b1; ctrl.do_done   = 1'b1; end
      default:            ctrl = '0;
    endcase
  end

endmodule
